// File: rtl/pac_pkg.sv
// pac_pkg: shared types, codes and constants of the power admission controller
// depends on nothing
`timescale 1ns / 1ps

package pac_pkg;

  localparam int NUM_MODULES_DEF = 10;

  localparam int KIND_W   = 2;
  localparam int IDX_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 4;
  localparam int MASK_W   = 10;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;

  localparam logic [KIND_W-1:0] KIND_ENABLE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RD_CMD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RD_STAT  = 2'd2;

  localparam logic [BYTE_W-1:0] CMD_OFF     = 8'd0;
  localparam logic [BYTE_W-1:0] CMD_ON      = 8'd1;
  localparam logic [BYTE_W-1:0] CMD_STANDBY = 8'd2;
  localparam logic [BYTE_W-1:0] REPLY_ERROR = 8'd255;

  localparam logic [1:0] PST_OFF        = 2'd0;
  localparam logic [1:0] PST_ON         = 2'd1;
  localparam logic [1:0] PST_GO_STANDBY = 2'd2;
  localparam logic [1:0] PST_ERROR      = 2'd3;

  localparam logic [STAT_W-1:0] STS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STS_ILLEGAL = 2'd1;
  localparam logic [STAT_W-1:0] STS_BLOCKED = 2'd2;
  localparam logic [STAT_W-1:0] STS_MOD_ERR = 2'd3;

  localparam logic [1:0] LOG_NONE    = 2'd0;
  localparam logic [1:0] LOG_BAD_CMD = 2'd1;
  localparam logic [1:0] LOG_BLOCKED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NORMAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEBUG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SB     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SB_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TROUBLE    = 3'd4;

  typedef struct packed {
    logic [1:0]        state;
    logic              sb_flag;
    logic              pwr_en;
    logic [BYTE_W-1:0] last_cmd;
    logic [STAT_W-1:0] last_stat;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0]  max_normal;
    logic [CNT_W-1:0]  max_debug;
    logic [CNT_W-1:0]  max_sb;
    logic [MASK_W-1:0] sb_mask;
    logic              trouble;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  module_index;
    logic [BYTE_W-1:0] command_byte;
    logic              enable_failed;
    logic              stop_failed;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] reply_byte;
    logic [STAT_W-1:0] reply_status;
    logic              power_on_pulse;
    logic              power_off_pulse;
    logic              stop_pulse;
    logic              wake_async;
    logic [1:0]        logged_error;
    logic [CNT_W-1:0]  powered_now;
    logic [CNT_W-1:0]  standby_now;
  } res_t;

endpackage

// File: rtl/pac_in_if.sv
// pac_in_if: request channel, valid/ready plus request fields
// depends on pac_pkg
`timescale 1ns / 1ps

interface pac_in_if
  import pac_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  module_index;
  logic [BYTE_W-1:0] command_byte;
  logic              enable_failed;
  logic              stop_failed;

  modport source (
    output valid, kind, module_index, command_byte, enable_failed, stop_failed,
    input  ready
  );
  modport sink (
    input  valid, kind, module_index, command_byte, enable_failed, stop_failed,
    output ready
  );
endinterface

// File: rtl/pac_out_if.sv
// pac_out_if: result channel, valid/ready plus result fields
// depends on pac_pkg
`timescale 1ns / 1ps

interface pac_out_if
  import pac_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] reply_byte;
  logic [STAT_W-1:0] reply_status;
  logic              power_on_pulse;
  logic              power_off_pulse;
  logic              stop_pulse;
  logic              wake_async;
  logic [1:0]        logged_error;
  logic [CNT_W-1:0]  powered_now;
  logic [CNT_W-1:0]  standby_now;

  modport source (
    output valid, reply_byte, reply_status, power_on_pulse, power_off_pulse,
           stop_pulse, wake_async, logged_error, powered_now, standby_now,
    input  ready
  );
  modport sink (
    input  valid, reply_byte, reply_status, power_on_pulse, power_off_pulse,
           stop_pulse, wake_async, logged_error, powered_now, standby_now,
    output ready
  );
endinterface

// File: rtl/power_admission_controller_unit.sv
// power_admission_controller_unit: top level of the power admission controller
// depends on pac_pkg, pac_in_if, pac_out_if, pac_cfg_regs, pac_state_mem, pac_update
//
//   port    | direction | transfers
//   in_ch   | sink      | request item: kind, module_index, command_byte, failure flags
//   out_ch  | source    | result item: reply, pulses, logged_error, counts
//   cfg_*   | write     | limit, mask and mode registers, indexes 0 to 4
//
// the accept step stores the request and issues the state memory read; the update
// stage then updates the entry, writes it back and loads the output register
// a new item is taken once the previous one has left the update stage
// a full output register holds the update stage until out_ch is ready
// reset clears the counters, the valid flags and the entry valid bits, and loads config defaults
`timescale 1ns / 1ps

module power_admission_controller_unit
  import pac_pkg::*;
#(
  parameter int NUM_MODULES = NUM_MODULES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pac_in_if.sink               in_ch,
  pac_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int AW = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;

  cfg_t             cfg;
  req_t             req_r;
  logic             pend_r;
  logic             out_vld_r;
  res_t             res_r;
  logic [CNT_W-1:0] pwr_cnt_r;
  logic [CNT_W-1:0] sb_cnt_r;

  logic             accept;
  logic             in_range;
  logic             fire;
  entry_t           rd_data;
  logic             upd_wr;
  entry_t           ent_nxt;
  logic [CNT_W-1:0] pwr_cnt_nxt;
  logic [CNT_W-1:0] sb_cnt_nxt;
  res_t             res_nxt;

  assign in_ch.ready = !pend_r;
  assign accept      = in_ch.valid && !pend_r;
  assign in_range    = ({1'b0, in_ch.module_index} < (IDX_W+1)'(NUM_MODULES));
  assign fire        = pend_r && (!out_vld_r || out_ch.ready);

  pac_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pac_state_mem #(
    .DEPTH (NUM_MODULES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && in_range),
    .rd_addr (in_ch.module_index[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (fire && upd_wr),
    .wr_addr (req_r.module_index[AW-1:0]),
    .wr_data (ent_nxt)
  );

  pac_update #(
    .NUM_MODULES (NUM_MODULES)
  ) u_upd (
    .req         (req_r),
    .ent         (rd_data),
    .cfg         (cfg),
    .pwr_cnt     (pwr_cnt_r),
    .sb_cnt      (sb_cnt_r),
    .wr_en       (upd_wr),
    .ent_nxt     (ent_nxt),
    .pwr_cnt_nxt (pwr_cnt_nxt),
    .sb_cnt_nxt  (sb_cnt_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.kind          <= in_ch.kind;
      req_r.module_index  <= in_ch.module_index;
      req_r.command_byte  <= in_ch.command_byte;
      req_r.enable_failed <= in_ch.enable_failed;
      req_r.stop_failed   <= in_ch.stop_failed;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
      pwr_cnt_r <= '0;
      sb_cnt_r  <= '0;
    end else begin
      if (accept) begin
        pend_r <= 1'b1;
      end else if (fire) begin
        pend_r <= 1'b0;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
        pwr_cnt_r <= pwr_cnt_nxt;
        sb_cnt_r  <= sb_cnt_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.reply_byte      = res_r.reply_byte;
  assign out_ch.reply_status    = res_r.reply_status;
  assign out_ch.power_on_pulse  = res_r.power_on_pulse;
  assign out_ch.power_off_pulse = res_r.power_off_pulse;
  assign out_ch.stop_pulse      = res_r.stop_pulse;
  assign out_ch.wake_async      = res_r.wake_async;
  assign out_ch.logged_error    = res_r.logged_error;
  assign out_ch.powered_now     = res_r.powered_now;
  assign out_ch.standby_now     = res_r.standby_now;

endmodule

// File: rtl/pac_cfg_regs.sv
// pac_cfg_regs: limit, mask and mode registers behind the write port
// depends on pac_pkg
`timescale 1ns / 1ps

module pac_cfg_regs
  import pac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_normal <= 4'd3;
      cfg_r.max_debug  <= 4'd10;
      cfg_r.max_sb     <= 4'd1;
      cfg_r.sb_mask    <= 10'd32;
      cfg_r.trouble    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_NORMAL: cfg_r.max_normal <= cfg_wdata[CNT_W-1:0];
        CFG_MAX_DEBUG:  cfg_r.max_debug  <= cfg_wdata[CNT_W-1:0];
        CFG_MAX_SB:     cfg_r.max_sb     <= cfg_wdata[CNT_W-1:0];
        CFG_SB_MASK:    cfg_r.sb_mask    <= cfg_wdata[MASK_W-1:0];
        CFG_TROUBLE:    cfg_r.trouble    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/pac_state_mem.sv
// pac_state_mem: per-module state memory, one write and one registered read port
// entries not yet written read as zero through per-entry valid bits; depends on pac_pkg
`timescale 1ns / 1ps

module pac_state_mem
  import pac_pkg::*;
#(
  parameter int DEPTH = NUM_MODULES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  entry_t           rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// File: rtl/pac_update.sv
// pac_update: admission decision and new entry, counters and result for one item
// combinational; depends on pac_pkg
`timescale 1ns / 1ps

module pac_update
  import pac_pkg::*;
#(
  parameter int NUM_MODULES = NUM_MODULES_DEF
) (
  input  req_t             req,
  input  entry_t           ent,
  input  cfg_t             cfg,
  input  logic [CNT_W-1:0] pwr_cnt,
  input  logic [CNT_W-1:0] sb_cnt,
  output logic             wr_en,
  output entry_t           ent_nxt,
  output logic [CNT_W-1:0] pwr_cnt_nxt,
  output logic [CNT_W-1:0] sb_cnt_nxt,
  output res_t             res
);

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  logic                   in_range;
  logic [(1<<IDX_W)-1:0]  mask_ext;
  logic                   sb_allowed;
  logic                   want_sb;
  logic [CNT_W-1:0]       limit;
  logic [STAT_W-1:0]      st;

  assign in_range   = ({1'b0, req.module_index} < (IDX_W+1)'(NUM_MODULES));
  assign mask_ext   = (1 << IDX_W)'(cfg.sb_mask);
  assign sb_allowed = ({1'b0, req.module_index} < (IDX_W+1)'(MASK_W))
                      && mask_ext[req.module_index];
  assign want_sb    = (req.command_byte == CMD_STANDBY);
  assign limit      = cfg.trouble ? cfg.max_debug : cfg.max_normal;

  always_comb begin
    wr_en       = 1'b0;
    ent_nxt     = ent;
    pwr_cnt_nxt = pwr_cnt;
    sb_cnt_nxt  = sb_cnt;
    res         = '0;
    st          = STS_OK;

    if (!in_range) begin
      res.reply_status = STS_ILLEGAL;
    end else begin
      case (req.kind)
        KIND_ENABLE: begin
          wr_en            = 1'b1;
          ent_nxt.last_cmd = req.command_byte;
          if (req.command_byte == CMD_OFF) begin
            if (ent.state != PST_OFF) begin
              res.stop_pulse      = 1'b1;
              res.power_off_pulse = 1'b1;
              if (req.stop_failed) begin
                st = STS_ILLEGAL;
              end
              if (req.enable_failed) begin
                st            = STS_ILLEGAL;
                ent_nxt.state = PST_ERROR;
              end else begin
                ent_nxt.pwr_en  = 1'b0;
                ent_nxt.state   = PST_OFF;
                ent_nxt.sb_flag = 1'b0;
                if (ent.sb_flag) begin
                  sb_cnt_nxt = dec_sat(sb_cnt);
                end else begin
                  pwr_cnt_nxt = dec_sat(pwr_cnt);
                end
              end
            end
          end else if (ent.state == PST_ERROR) begin
            st = STS_MOD_ERR;
          end else if (want_sb && !sb_allowed) begin
            res.logged_error = LOG_BAD_CMD;
            st               = STS_BLOCKED;
          end else if (req.command_byte != CMD_ON && !want_sb) begin
            res.logged_error = LOG_BAD_CMD;
            st               = STS_ILLEGAL;
          end else if (ent.state != PST_OFF && ent.sb_flag == want_sb) begin
            st = STS_OK;
          end else if (ent.state == PST_OFF) begin
            if (want_sb ? (sb_cnt >= cfg.max_sb) : (pwr_cnt >= limit)) begin
              res.logged_error = LOG_BLOCKED;
              st               = STS_BLOCKED;
            end else begin
              res.power_on_pulse = 1'b1;
              if (req.enable_failed) begin
                st = STS_ILLEGAL;
              end else begin
                ent_nxt.pwr_en = 1'b1;
                ent_nxt.state  = PST_ON;
                res.wake_async = 1'b1;
                if (want_sb) begin
                  ent_nxt.sb_flag = 1'b1;
                  sb_cnt_nxt      = inc_sat(sb_cnt);
                end else begin
                  pwr_cnt_nxt = inc_sat(pwr_cnt);
                end
              end
            end
          end else if (!want_sb) begin
            if (pwr_cnt >= limit) begin
              res.logged_error = LOG_BLOCKED;
              st               = STS_BLOCKED;
            end else begin
              ent_nxt.sb_flag = 1'b0;
              sb_cnt_nxt      = dec_sat(sb_cnt);
              pwr_cnt_nxt     = inc_sat(pwr_cnt);
            end
          end else begin
            if (sb_cnt >= cfg.max_sb) begin
              res.logged_error = LOG_BLOCKED;
              st               = STS_BLOCKED;
            end else begin
              ent_nxt.sb_flag = 1'b1;
              sb_cnt_nxt      = inc_sat(sb_cnt);
              pwr_cnt_nxt     = dec_sat(pwr_cnt);
              ent_nxt.state   = PST_GO_STANDBY;
              res.wake_async  = 1'b1;
            end
          end
          ent_nxt.last_stat = st;
          res.reply_status  = st;
        end
        KIND_RD_CMD: begin
          res.reply_byte   = ent.last_cmd;
          res.reply_status = ent.last_stat;
        end
        KIND_RD_STAT: begin
          if (ent.state == PST_ERROR) begin
            res.reply_byte   = REPLY_ERROR;
            res.reply_status = STS_MOD_ERR;
          end else begin
            res.reply_byte = BYTE_W'(ent.pwr_en) + BYTE_W'(ent.sb_flag);
          end
        end
        default: begin
        end
      endcase
    end

    res.powered_now = pwr_cnt_nxt;
    res.standby_now = sb_cnt_nxt;
  end

endmodule
